// ===== src/greedy_weight_partitioner_assert.svh =====
// ----------------------------------------------------------------------------
// Greedy weight partitioner assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WEIGHT_PARTITIONER_ASSERT_SVH
`define GREEDY_WEIGHT_PARTITIONER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GWP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gwp check failed");

// next-cycle implication
`define GWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gwp check failed");

`else

`define GWP_ASSERT_SAME(label, clk, rst, ante, cons)
`define GWP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/gwp_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy weight partitioner package
// Field widths, register indexes and the saturating adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwp_pkg;

   localparam int ID_W      = 16;
   localparam int WGT_W     = 32;
   localparam int SUM_W     = 48;
   localparam int CNT_W     = 11;
   localparam int BIN_OUT_W = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_TARGET = 1'b1;

   typedef logic [SUM_W-1:0] sum_type;

   // add, clamp at all ones
   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

// ===== src/greedy_weight_partitioner.sv =====
// ----------------------------------------------------------------------------
// Greedy weight partitioner
// Assigns a stream of weighted items, in order, to bins of a target weight,
// with back-off of the closing item when the running total overshoots.
// ----------------------------------------------------------------------------
//   channel | ports                      | dir | transfer
//   --------+----------------------------+-----+---------------------------
//   req     | start_req, item_id, weight | in  | valid/ready word
//   rsp     | item_id_out, bin, closed   | out | valid/ready word
//   csr     | we, index, wdata           | in  | write on we, no stall
//
// One word per cycle sustained while rsp is ready; a word passes the input
// register, then the result register. The bin state loop (bin, sum, total)
// closes through one 48 x 11 multiply for the bin threshold and one compare.
// Synchronous active-high reset clears state to bin 0 and the registers to
// count 1, target 1. A stalled rsp side holds the result register; the input
// register still drains into it once it empties, so req stalls only when both
// stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "greedy_weight_partitioner_assert.svh"

module greedy_weight_partitioner #(
   parameter int MAX_BINS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_start_req,
   input  logic [gwp_pkg::ID_W-1:0]          req_item_id,
   input  logic [gwp_pkg::WGT_W-1:0]         req_weight,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gwp_pkg::ID_W-1:0]          rsp_item_id_out,
   output logic [gwp_pkg::BIN_OUT_W-1:0]     rsp_bin,
   output logic                              rsp_bin_closed,
   // register writes
   input  logic                              csr_we,
   input  logic [gwp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gwp_pkg::SUM_W-1:0]         csr_wdata
);

   import gwp_pkg::*;

   // bin_count is 11 bits, so at most 2047 bins are reachable
   localparam int EffMax = (MAX_BINS > 2047) ? 2047 : MAX_BINS;
   localparam int BinW   = $clog2(EffMax);
   localparam logic [CNT_W-1:0] EffMaxC = CNT_W'(EffMax);

   // ---------------------------------------------------------------- csrs
   logic [CNT_W-1:0] bin_count_ff;
   sum_type          bin_target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff  <= CNT_W'(1);
         bin_target_ff <= SUM_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIN_COUNT:  bin_count_ff  <= csr_wdata[CNT_W-1:0];
            CSR_BIN_TARGET: bin_target_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------- input register
   logic              in_valid_ff;
   logic              in_start_ff;
   logic [ID_W-1:0]   in_id_ff;
   logic [WGT_W-1:0]  in_weight_ff;
   logic              out_valid_ff;
   logic              advance;

   // input word moves on when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff  <= req_start_req;
         in_id_ff     <= req_item_id;
         in_weight_ff <= req_weight;
      end
   end

   // ----------------------------------------------------------- bin state
   logic [BinW-1:0] cur_bin_ff, cur_bin_in;
   sum_type         bin_sum_ff, bin_sum_in;
   sum_type         tot_ff, tot_in;
   logic            has_item_ff, has_item_in;

   // ---------------------------------------------------------- next state
   logic [CNT_W-1:0]     cnt_eff;
   logic [CNT_W-1:0]     last_w;
   logic [BinW-1:0]      last;
   logic [BinW-1:0]      cur_s;
   sum_type              sum_s;
   sum_type              tot_s;
   logic                 has_s;
   logic [BinW-1:0]      b;
   logic [BinW-1:0]      b_next;
   logic [BinW:0]        b_plus;
   logic [SUM_W+BinW:0]  prod;
   sum_type              thr;
   sum_type              w48;
   sum_type              new_sum;
   sum_type              new_tot;
   logic [BinW-1:0]      bin_res;
   logic                 closed;
   logic [BinW+BIN_OUT_W-1:0] bin_wide;

   always_comb begin
      // clamp the count into 1..EffMax
      if (bin_count_ff == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (bin_count_ff > EffMaxC) begin
         cnt_eff = EffMaxC;
      end else begin
         cnt_eff = bin_count_ff;
      end
      last_w = cnt_eff - CNT_W'(1);
      last   = last_w[BinW-1:0];

      // start request wipes the running state
      cur_s = in_start_ff ? '0 : cur_bin_ff;
      sum_s = in_start_ff ? '0 : bin_sum_ff;
      tot_s = in_start_ff ? '0 : tot_ff;
      has_s = in_start_ff ? 1'b0 : has_item_ff;

      // count lowered mid-partition: pull back to the last bin
      if (cur_s > last) begin
         cur_s = last;
      end
      // zero target: skip straight to the last bin
      if (cur_s < last && bin_target_ff == '0) begin
         tot_s = sat_add(tot_s, sum_s);
         sum_s = '0;
         has_s = 1'b0;
         cur_s = last;
      end

      b      = cur_s;
      b_next = b + BinW'(1);
      b_plus = {1'b0, b} + (BinW+1)'(1);
      prod   = {{(BinW+1){1'b0}}, bin_target_ff} * {{SUM_W{1'b0}}, b_plus};
      thr    = (|prod[SUM_W+BinW:SUM_W]) ? {SUM_W{1'b1}} : prod[SUM_W-1:0];

      w48     = {{(SUM_W-WGT_W){1'b0}}, in_weight_ff};
      new_sum = sat_add(sum_s, w48);
      new_tot = sat_add(tot_s, new_sum);

      cur_bin_in  = cur_s;
      bin_sum_in  = sum_s;
      tot_in      = tot_s;
      has_item_in = has_s;
      bin_res     = b;
      closed      = 1'b0;

      if (b == last) begin
         // last bin takes everything
         bin_sum_in  = new_sum;
         has_item_in = 1'b1;
      end else if (new_sum < bin_target_ff) begin
         bin_sum_in  = new_sum;
         has_item_in = 1'b1;
      end else if (new_tot > thr && has_s) begin
         // overshoot: closing item opens the next bin instead
         bin_res     = b_next;
         cur_bin_in  = b_next;
         tot_in      = sat_add(tot_s, sum_s);
         bin_sum_in  = w48;
         has_item_in = 1'b1;
         if (b_next < last && w48 >= bin_target_ff) begin
            // lone item fills that bin too; sum of saturating adds is new_tot
            tot_in      = new_tot;
            bin_sum_in  = '0;
            has_item_in = 1'b0;
            cur_bin_in  = b_next + BinW'(1);
            closed      = 1'b1;
         end
      end else begin
         tot_in      = new_tot;
         bin_sum_in  = '0;
         has_item_in = 1'b0;
         cur_bin_in  = b_next;
         closed      = 1'b1;
      end

      bin_wide = {{BIN_OUT_W{1'b0}}, bin_res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bin_ff  <= '0;
         bin_sum_ff  <= '0;
         tot_ff      <= '0;
         has_item_ff <= 1'b0;
      end else if (advance) begin
         cur_bin_ff  <= cur_bin_in;
         bin_sum_ff  <= bin_sum_in;
         tot_ff      <= tot_in;
         has_item_ff <= has_item_in;
      end
   end

   // ------------------------------------------------------- result register
   logic [ID_W-1:0]      out_id_ff;
   logic [BIN_OUT_W-1:0] out_bin_ff;
   logic                 out_closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= advance || (out_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_id_ff     <= in_id_ff;
         out_bin_ff    <= bin_wide[BIN_OUT_W-1:0];
         out_closed_ff <= closed;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_item_id_out = out_id_ff;
   assign rsp_bin         = out_bin_ff;
   assign rsp_bin_closed  = out_closed_ff;

   // ------------------------------------------------------------ checks
   `GWP_ASSERT_SAME(a_bin_in_range, clock, reset, 1'b1, cur_bin_ff <= BinW'(EffMax - 1))
   `GWP_ASSERT_SAME(a_empty_bin_zero, clock, reset, !has_item_ff, bin_sum_ff == '0)
   `GWP_ASSERT_NEXT(a_close_clears, clock, reset, advance && closed,
      !has_item_ff && bin_sum_ff == '0)
   `GWP_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
      in_valid_ff && out_valid_ff)

endmodule

// ===== sim/tb_greedy_weight_partitioner.sv =====
// ----------------------------------------------------------------------------
// Greedy weight partitioner testbench
// A queue-fed driver offers request words with random gaps. A monitor takes
// result words with random stalls and checks each one against a bin
// placement model kept in the bench. The stimulus runs in phases: a directed
// set of corner cases, random register settings with mostly well-formed
// partitions, and a short back-to-back burst of maximum weights at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_greedy_weight_partitioner;

   import gwp_pkg::*;

   localparam int                 BIN_CAP   = 1024;
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [WGT_W-1:0]   WGT_MAX   = {WGT_W{1'b1}};
   localparam int                 GAP_MAX   = 17;
   localparam int                 BURST_LEN = 80;
   localparam int                 PRINT_CAP = 40;

   // one request word as the driver sees it
   typedef struct packed {
      logic             start;
      logic [ID_W-1:0]  id;
      logic [WGT_W-1:0] weight;
   } part_req_type;

   // one expected placement
   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [BIN_OUT_W-1:0] bin;
      logic                 closed;
   } placement_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_start_req = 1'b0;
   logic [ID_W-1:0]      req_item_id   = '0;
   logic [WGT_W-1:0]     req_weight    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [ID_W-1:0]      rsp_item_id_out;
   logic [BIN_OUT_W-1:0] rsp_bin;
   logic                 rsp_bin_closed;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = CSR_BIN_COUNT;
   logic [SUM_W-1:0]     csr_wdata     = '0;

   greedy_weight_partitioner #(
      .MAX_BINS (BIN_CAP)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_item_id     (req_item_id),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_id_out (rsp_item_id_out),
      .rsp_bin         (rsp_bin),
      .rsp_bin_closed  (rsp_bin_closed),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Placement model: register copies and running partition state
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0]     bins_cfg     = 11'd1;
   logic [SUM_W-1:0]     target_cfg   = 48'd1;
   logic [CNT_W-1:0]     cur_bin      = '0;   // bin that takes the next word
   logic [SUM_W-1:0]     fill         = '0;   // weight in the current bin
   logic [SUM_W-1:0]     closed_total = '0;   // weight of all closed bins
   logic                 has_item     = 1'b0;

   function automatic logic [SUM_W-1:0] clamp_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [63:0] s;
      s = 64'(a) + 64'(b);
      return (s > 64'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   // running threshold: target times bins so far, clamped
   function automatic logic [SUM_W-1:0] bin_limit(input logic [CNT_W-1:0] b);
      logic [63:0] p;
      p = 64'(target_cfg) * (64'(b) + 64'd1);
      return (p > 64'(SUM_MAX)) ? SUM_MAX : p[SUM_W-1:0];
   endfunction

   function automatic placement_type place_item(input part_req_type rq);
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] last;
      logic [CNT_W-1:0] b;
      logic [SUM_W-1:0] w;
      logic [SUM_W-1:0] ns;
      logic [SUM_W-1:0] tot;
      logic             closed;
      placement_type    res;
      w      = 48'(rq.weight);
      closed = 1'b0;
      // zero bins act as one, too many act as the cap
      cnt = bins_cfg;
      if (cnt == 0) cnt = 11'd1;
      if (cnt > BIN_CAP) cnt = CNT_W'(BIN_CAP);
      last = cnt - 11'd1;
      if (rq.start) begin
         cur_bin      = '0;
         fill         = '0;
         closed_total = '0;
         has_item     = 1'b0;
      end
      // bin count lowered mid-partition: fall back to the last bin
      if (cur_bin > last) cur_bin = last;
      // zero target: skip straight to the last bin
      if (cur_bin < last && target_cfg == 0) begin
         closed_total = clamp_add(closed_total, fill);
         fill         = '0;
         has_item     = 1'b0;
         cur_bin      = last;
      end
      b = cur_bin;
      if (b == last) begin
         fill     = clamp_add(fill, w);
         has_item = 1'b1;
      end else begin
         ns = clamp_add(fill, w);
         if (ns < target_cfg) begin
            fill     = ns;
            has_item = 1'b1;
         end else begin
            tot = clamp_add(closed_total, ns);
            if (tot > bin_limit(b) && has_item) begin
               // overshoot: closing word opens the next bin instead
               closed_total = clamp_add(closed_total, fill);
               b            = b + 11'd1;
               cur_bin      = b;
               fill         = w;
               has_item     = 1'b1;
               if (b < last && w >= target_cfg) begin
                  closed_total = clamp_add(closed_total, w);
                  fill         = '0;
                  has_item     = 1'b0;
                  cur_bin      = b + 11'd1;
                  closed       = 1'b1;
               end
            end else begin
               closed_total = tot;
               fill         = '0;
               has_item     = 1'b0;
               cur_bin      = b + 11'd1;
               closed       = 1'b1;
            end
         end
      end
      res.id     = rq.id;
      res.bin    = b[BIN_OUT_W-1:0];
      res.closed = closed;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   part_req_type   pending_q[$];     // words not yet offered
   placement_type  placement_q[$];   // placements awaiting their result word
   bit          jitter_on   = 1'b0;
   int unsigned words_sent  = 0;
   int unsigned results_seen = 0;
   int unsigned closes_seen = 0;
   int unsigned long_holds  = 0;
   int unsigned mismatches  = 0;
   int unsigned settings    = 0;

   // ------------------------------------------------------------------------
   // Driver: pops pending words, random gap after each accepted word.
   // Valid gets a single NBA per edge, so back-to-back words never glitch.
   // ------------------------------------------------------------------------
   part_req_type offered;
   int unsigned  gap_left = 0;
   logic         drv_next_valid;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         drv_next_valid = req_valid;
         if (req_valid && req_ready) begin
            placement_q.insert(placement_q.size(), place_item(offered));
            words_sent++;
            drv_next_valid = 1'b0;
            gap_left = jitter_on ? $urandom_range(0, GAP_MAX) : 0;
         end
         if (!drv_next_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               offered        = pending_q.pop_front();
               req_start_req  <= offered.start;
               req_item_id    <= offered.id;
               req_weight     <= offered.weight;
               drv_next_valid = 1'b1;
            end
         end
         req_valid <= drv_next_valid;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random stall after each result, plus a few long hold-offs while
   // the sender still has words queued so both stages fill and req stalls.
   // ------------------------------------------------------------------------
   int unsigned   stall_left = 0;
   int unsigned   hold_left  = 0;
   placement_type want;

   task automatic report_field(input string field, input longint unsigned exp_v,
                               input longint unsigned act_v);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_v, act_v);
      else if (mismatches == PRINT_CAP + 1)
         $display("%0t ns: further mismatches counted, not printed", $time);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_bin_closed) closes_seen++;
            if (placement_q.size() == 0) begin
               report_field("unexpected word, item_id", 0, rsp_item_id_out);
            end else begin
               want = placement_q.pop_front();
               if (rsp_item_id_out !== want.id)
                  report_field("item_id_out", want.id, rsp_item_id_out);
               if (rsp_bin !== want.bin)
                  report_field("bin", want.bin, rsp_bin);
               if (rsp_bin_closed !== want.closed)
                  report_field("bin_closed", want.closed, rsp_bin_closed);
            end
            stall_left = jitter_on ? $urandom_range(0, GAP_MAX) : 0;
            // first chance always taken, later ones at random
            if (long_holds < 3 && pending_q.size() > 8 &&
                (long_holds == 0 || $urandom_range(0, 63) == 0)) begin
               hold_left = $urandom_range(60, 120);
               long_holds++;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_word(input logic start, input logic [ID_W-1:0] id,
                             input logic [WGT_W-1:0] weight);
      part_req_type rq;
      rq.start  = start;
      rq.id     = id;
      rq.weight = weight;
      pending_q.insert(pending_q.size(), rq);
   endtask

   // every word accepted and every result returned; sampled away from the
   // rising edge so the driver's updates there are already settled
   task automatic wait_drain();
      while (pending_q.size() != 0 || req_valid || placement_q.size() != 0)
         @(negedge clock);
   endtask

   // register write; model copy follows, block is idle here
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [SUM_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BIN_COUNT) bins_cfg = data[CNT_W-1:0];
      else                      target_cfg = data;
      settings++;
   endtask

   task automatic random_phase(input int unsigned n);
      logic [SUM_W-1:0] cnt;
      logic [SUM_W-1:0] tgt;
      logic [WGT_W-1:0] w;
      bit               heavy;
      bit               carry;
      case ($urandom_range(0, 5))
         0: begin
            cnt = 48'd1;
         end
         1: begin
            cnt = 48'($urandom_range(2, 8));
         end
         2: begin
            cnt = 48'($urandom_range(9, 64));
         end
         3: begin
            cnt = 48'(BIN_CAP);
         end
         4: begin
            cnt = $urandom_range(0, 1) ? 48'd0 : 48'd2047;
         end
         default: begin
            cnt = 48'($urandom_range(2, BIN_CAP));
         end
      endcase
      heavy = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 11) == 0)
         tgt = '0;
      else if (heavy)
         tgt = {13'd0, 3'($urandom_range(0, 7)), 32'($urandom)};
      else
         tgt = 48'($urandom_range(1, 700));
      // sometimes keep the old partition running across the new setting
      carry     = ($urandom_range(0, 3) == 0);
      jitter_on = ($urandom_range(0, 3) != 0);
      write_reg(CSR_BIN_COUNT, cnt);
      write_reg(CSR_BIN_TARGET, tgt);
      for (int unsigned i = 0; i < n; i++) begin
         if (heavy)
            w = ($urandom_range(0, 15) == 0) ? WGT_MAX : 32'($urandom);
         else
            w = ($urandom_range(0, 15) == 0) ? '0 : 32'($urandom_range(0, 255));
         queue_word((i == 0 && !carry) || $urandom_range(0, 39) == 0,
                    16'($urandom), w);
      end
      wait_drain();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset state is a valid start: no start flag, reset registers
      jitter_on = 1'b1;
      queue_word(1'b0, 16'h0000, 32'd5);
      queue_word(1'b0, 16'hFFFF, WGT_MAX);
      wait_drain();

      // four bins of 100: plain fill, back-off, close, back-off into last
      write_reg(CSR_BIN_COUNT, 48'd4);
      write_reg(CSR_BIN_TARGET, 48'd100);
      queue_word(1'b1, 16'd1, 32'd30);
      queue_word(1'b0, 16'd2, 32'd50);
      queue_word(1'b0, 16'd3, 32'd40);
      queue_word(1'b0, 16'd4, 32'd60);
      queue_word(1'b0, 16'd5, 32'd0);
      queue_word(1'b0, 16'd6, WGT_MAX);
      queue_word(1'b0, 16'd7, 32'd7);
      // lone heavy word closes an empty bin; back-off word closes next bin
      queue_word(1'b1, 16'd8, WGT_MAX);
      queue_word(1'b0, 16'd9, 32'd10);
      queue_word(1'b0, 16'd10, 32'd500);
      queue_word(1'b0, 16'd11, 32'd1);
      wait_drain();

      // fewer bins mid-partition: current bin pulled back to the last
      write_reg(CSR_BIN_COUNT, 48'd2);
      queue_word(1'b0, 16'd12, 32'd3);
      wait_drain();

      // zero target with weight already in the current bin
      write_reg(CSR_BIN_COUNT, 48'd8);
      write_reg(CSR_BIN_TARGET, 48'd1000);
      queue_word(1'b1, 16'd13, 32'd300);
      wait_drain();
      write_reg(CSR_BIN_TARGET, 48'd0);
      queue_word(1'b0, 16'd14, 32'd20);
      wait_drain();

      // bin count zero acts as one
      write_reg(CSR_BIN_COUNT, 48'd0);
      write_reg(CSR_BIN_TARGET, 48'd1);
      queue_word(1'b1, 16'd15, 32'd2);
      wait_drain();

      // bin count above the cap, largest target, then target one
      write_reg(CSR_BIN_COUNT, 48'd2047);
      write_reg(CSR_BIN_TARGET, SUM_MAX);
      queue_word(1'b1, 16'd16, WGT_MAX);
      wait_drain();
      write_reg(CSR_BIN_TARGET, 48'd1);
      queue_word(1'b1, 16'd17, 32'd1);
      queue_word(1'b0, 16'd18, 32'd0);
      queue_word(1'b0, 16'd19, 32'd2);
      wait_drain();

      // random settings, mostly well-formed partitions
      for (int p = 0; p < 10; p++)
         random_phase(50);

      // full rate: back-to-back maximum weights into the first of two bins
      // under the largest target
      jitter_on = 1'b0;
      write_reg(CSR_BIN_COUNT, 48'd2);
      write_reg(CSR_BIN_TARGET, SUM_MAX);
      for (int unsigned i = 0; i < BURST_LEN; i++)
         queue_word(i == 0, 16'(i), WGT_MAX);
      wait_drain();

      // catch any stray result word after the last one
      repeat (8) @(posedge clock);
      mismatches += placement_q.size();

      $display("Run: %0d request words, %0d result words over %0d register writes",
               words_sent, results_seen, settings);
      $display("     %0d bins closed, %0d long result hold-offs, %0d mismatches",
               closes_seen, long_holds, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("%0t ns: watchdog expired", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
